FILE: rtl/bresenham_line_rasterizer_top_defines.svh
// ----------------------------------------------------------------------------
// Bresenham line rasterizer: assertion macros
// Implication checks, clocked on a given clock, off while reset is low.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BLR_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("blr assertion failed");

// next-cycle implication
`define BLR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("blr assertion failed");

`else

`define BLR_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define BLR_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// Shared widths, payload types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int COORD_BITS = 6;
    localparam int COLOR_BITS = 16;
    localparam int ERR_BITS   = COORD_BITS + 2;

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic [COLOR_BITS-1:0]      t_color;
    typedef logic signed [ERR_BITS-1:0] t_err;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic last;
        logic room;
    } t_dp_status;

endpackage

FILE: rtl/bresenham_line_rasterizer_top.sv
// The request is captured, the line is set up, then each step registers one pixel.
// Throughput: one pixel per cycle through the single error-update step while the output has room.
// Output back-pressure stalls the walk; the next request is taken in idle.
// Reset (synchronous, active low) clears the sequencer and output valid only.
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top
// Line command in, one pixel per result out, last pixel flagged.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  blr_pkg::t_coord i_start_x,
    input  blr_pkg::t_coord i_start_y,
    input  blr_pkg::t_coord i_end_x,
    input  blr_pkg::t_coord i_end_y,
    input  blr_pkg::t_color i_pixel_color,
    output logic            o_valid,
    input  logic            i_ready,
    output blr_pkg::t_coord o_pixel_x,
    output blr_pkg::t_coord o_pixel_y,
    output blr_pkg::t_color o_out_color,
    output logic            o_last_pixel
);
    import blr_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    blr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    blr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_pixel_color (i_pixel_color),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_out_color   (o_out_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

FILE: rtl/blr_ctrl.sv
// ----------------------------------------------------------------------------
// blr_ctrl
// Sequencer: capture request, set up line, then step one pixel per cycle while the output has room.
// ----------------------------------------------------------------------------
`include "bresenham_line_rasterizer_top_defines.svh"

module blr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  blr_pkg::t_dp_status i_status,
    output blr_pkg::t_dp_cmd    o_cmd
);
    import blr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_ready     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_RUN;
            end
            ST_RUN: begin
                if (i_status.done) begin
                    n_state = ST_IDLE;
                end else if (i_status.room) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `BLR_ASSERT_NEXT(a_setup_to_run, i_clk, i_rst_n, r_state == ST_SETUP, r_state == ST_RUN)
    `BLR_ASSERT_SAME(a_step_has_room, i_clk, i_rst_n, o_cmd.step,
        r_state == ST_RUN && i_status.room && !i_status.done)
    `BLR_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_cmd.step && i_status.last,
        r_state == ST_IDLE)

endmodule

FILE: rtl/blr_dp.sv
// ----------------------------------------------------------------------------
// blr_dp
// Line setup (octant, ordering, deltas), error stepping and output register.
// ----------------------------------------------------------------------------
module blr_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  blr_pkg::t_dp_cmd    i_cmd,
    output blr_pkg::t_dp_status o_status,
    input  blr_pkg::t_coord     i_start_x,
    input  blr_pkg::t_coord     i_start_y,
    input  blr_pkg::t_coord     i_end_x,
    input  blr_pkg::t_coord     i_end_y,
    input  blr_pkg::t_color     i_pixel_color,
    output logic                o_valid,
    input  logic                i_ready,
    output blr_pkg::t_coord     o_pixel_x,
    output blr_pkg::t_coord     o_pixel_y,
    output blr_pkg::t_color     o_out_color,
    output logic                o_last_pixel
);
    import blr_pkg::*;

    // captured request
    t_coord r_ax, r_ay, r_bx, r_by;
    t_color r_color;

    // walk state
    logic   r_steep;
    logic   r_dir;
    t_coord r_maj, r_min, r_dmaj, r_dmin, r_remain;
    t_err   r_err;

    // output register
    logic   r_out_valid;
    t_coord r_px, r_py;
    t_color r_pc;
    logic   r_plast;

    // setup logic
    t_coord adx, ady, maj0, min0, maj1, min1, s_maj0, s_min0, s_maj1, s_min1;
    logic   steep, swap;

    // step logic
    t_err   err_sum;
    logic   min_step;

    always_comb begin
        adx   = (r_bx > r_ax) ? (r_bx - r_ax) : (r_ax - r_bx);
        ady   = (r_by > r_ay) ? (r_by - r_ay) : (r_ay - r_by);
        steep = ady > adx;
        maj0  = steep ? r_ay : r_ax;
        min0  = steep ? r_ax : r_ay;
        maj1  = steep ? r_by : r_bx;
        min1  = steep ? r_bx : r_by;
        swap  = maj0 > maj1;
        s_maj0 = swap ? maj1 : maj0;
        s_min0 = swap ? min1 : min0;
        s_maj1 = swap ? maj0 : maj1;
        s_min1 = swap ? min0 : min1;
    end

    always_comb begin
        err_sum  = r_err + t_err'({2'b00, r_dmin});
        min_step = err_sum > t_err'(0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax    <= i_start_x;
            r_ay    <= i_start_y;
            r_bx    <= i_end_x;
            r_by    <= i_end_y;
            r_color <= i_pixel_color;
        end
        if (i_cmd.setup) begin
            r_steep  <= steep;
            r_maj    <= s_maj0;
            r_min    <= s_min0;
            r_dmaj   <= s_maj1 - s_maj0;
            r_remain <= s_maj1 - s_maj0;
            r_dmin   <= (s_min1 > s_min0) ? (s_min1 - s_min0) : (s_min0 - s_min1);
            r_dir    <= s_min0 < s_min1;
            r_err    <= -t_err'({2'b00, (s_maj1 - s_maj0) >> 1});
        end else if (i_cmd.step) begin
            r_maj    <= r_maj + t_coord'(1);
            r_remain <= r_remain - t_coord'(1);
            if (min_step) begin
                r_min <= r_dir ? (r_min + t_coord'(1)) : (r_min - t_coord'(1));
                r_err <= err_sum - t_err'({2'b00, r_dmaj});
            end else begin
                r_err <= err_sum;
            end
        end
        if (i_cmd.step) begin
            r_px    <= r_steep ? r_min : r_maj;
            r_py    <= r_steep ? r_maj : r_min;
            r_pc    <= r_color;
            r_plast <= r_remain == t_coord'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.done = r_remain == t_coord'(0);
    assign o_status.last = r_remain == t_coord'(1);
    assign o_status.room = !r_out_valid || i_ready;

    assign o_valid      = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_out_color  = r_pc;
    assign o_last_pixel = r_plast;

endmodule
